/* rtl/core/acs_pkg.sv */
package acs_pkg;

    localparam int TABLE_SIZE = 512;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_W   = FRAC_BITS + 1;
    localparam int PROD_W     = WEIGHT_W + IDX_W;
    localparam int SCL_W      = PROD_W + 2;
    localparam int CFG_W      = 10;

    localparam logic [SCL_W-1:0]    ONE_SCL = SCL_W'(1) << FRAC_BITS;
    localparam logic [WEIGHT_W-1:0] ONE_THR = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]    N_MAX   = CNT_W'(TABLE_SIZE);

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMP,
        S_BUILD,
        S_PAIR_IDX,
        S_PAIR_UPD,
        S_LEFT_L,
        S_LEFT_S
    } t_state;

    typedef struct packed {
        t_op                 op;
        t_status             status;
        logic [IDX_W-1:0]    idx;
        logic [PROD_W-1:0]   scaled;
        logic                last;
        logic [FRAC_BITS-1:0] frac;
    } t_req;

endpackage

/* rtl/core/acs_front.sv */
module acs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_operation,
    input  logic [8:0]     i_entry_index,
    input  logic [16:0]    i_weight,
    input  logic           i_last_entry,
    input  logic [8:0]     i_random_slot,
    input  logic [15:0]    i_random_fraction,
    input  logic           i_cfg_valid,
    input  logic [9:0]     i_cfg_data,
    output logic           o_push,
    output acs_pkg::t_req  o_req,
    output logic           o_cfg_clr
);
    import acs_pkg::*;

    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] idx;
    logic             in_range;

    always_comb begin
        n_n = r_n;
        if (i_cfg_data == '0) begin
            n_n = CNT_W'(1);
        end else if (CNT_W'(i_cfg_data) > N_MAX) begin
            n_n = N_MAX;
        end else begin
            n_n = CNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= N_MAX;
        end else if (i_cfg_valid) begin
            r_n <= n_n;
        end
    end

    assign o_cfg_clr = i_cfg_valid;
    assign o_push    = i_valid;
    assign idx       = (t_op'(i_operation) == OP_LOAD) ? i_entry_index : i_random_slot;
    assign in_range  = CNT_W'(idx) < r_n;

    always_comb begin
        o_req.op     = t_op'(i_operation);
        o_req.status = in_range ? ST_OK : ST_RANGE;
        o_req.idx    = idx;
        o_req.scaled = PROD_W'(i_weight * r_n);
        o_req.last   = i_last_entry;
        o_req.frac   = i_random_fraction;
    end
endmodule

/* rtl/core/acs_queue.sv */
module acs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acs_pkg::t_req  i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output acs_pkg::t_req  o_req
);
    import acs_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end
endmodule

/* rtl/core/acs_back.sv */
module acs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_clr,
    input  logic           i_q_valid,
    input  acs_pkg::t_req  i_req,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [8:0]     o_sampled_outcome
);
    import acs_pkg::*;

    logic [SCL_W-1:0]    scl_mem [TABLE_SIZE];
    logic [WEIGHT_W-1:0] thr_mem [TABLE_SIZE];
    logic [IDX_W-1:0]    als_mem [TABLE_SIZE];
    logic [IDX_W-1:0]    sm_stk  [TABLE_SIZE];
    logic [IDX_W-1:0]    lg_stk  [TABLE_SIZE];

    t_state           r_st, n_st;
    logic [CNT_W-1:0] r_sc, n_sc, r_lc, n_lc;
    logic             r_rdy, n_rdy;
    logic             r_ov, n_ov;
    t_status          r_stat, n_stat;
    logic [IDX_W-1:0] r_out, n_out;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic [IDX_W-1:0] r_lo, n_lo, r_hi, n_hi;

    logic [SCL_W-1:0]    scl_lo_q, scl_hi_q;
    logic [WEIGHT_W-1:0] thr_q;
    logic [IDX_W-1:0]    als_q, sm_q, lg_q;
    logic [IDX_W-1:0]    tbl_ra;

    logic                scl_we, tbl_we, sm_we, lg_we;
    logic [IDX_W-1:0]    scl_wa, tbl_wa, sm_wa, lg_wa, sm_wd, lg_wd, als_wd;
    logic [SCL_W-1:0]    scl_wd, sum;
    logic [WEIGHT_W-1:0] thr_wd;
    logic                out_free;
    logic [CNT_W-1:0]    sc_m1, lc_m1;

    assign out_free = !r_ov || i_ready;
    assign sc_m1    = r_sc - CNT_W'(1);
    assign lc_m1    = r_lc - CNT_W'(1);
    assign sum      = scl_hi_q + scl_lo_q - ONE_SCL;
    assign tbl_ra   = (r_st == S_IDLE) ? i_req.idx : r_slot;

    always_ff @(posedge i_clk) begin
        if (scl_we) scl_mem[scl_wa] <= scl_wd;
        if (tbl_we) begin
            thr_mem[tbl_wa] <= thr_wd;
            als_mem[tbl_wa] <= als_wd;
        end
        if (sm_we) sm_stk[sm_wa] <= sm_wd;
        if (lg_we) lg_stk[lg_wa] <= lg_wd;
        scl_lo_q <= scl_mem[sm_q];
        scl_hi_q <= scl_mem[lg_q];
        thr_q    <= thr_mem[tbl_ra];
        als_q    <= als_mem[tbl_ra];
        sm_q     <= sm_stk[sc_m1[IDX_W-1:0]];
        lg_q     <= lg_stk[lc_m1[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_sc  <= '0;
            r_lc  <= '0;
            r_rdy <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_sc  <= n_sc;
            r_lc  <= n_lc;
            r_rdy <= n_rdy;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat <= n_stat;
        r_out  <= n_out;
        r_slot <= n_slot;
        r_frac <= n_frac;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
    end

    always_comb begin
        n_st   = r_st;
        n_sc   = r_sc;
        n_lc   = r_lc;
        n_rdy  = r_rdy;
        n_ov   = r_ov && !i_ready;
        n_stat = r_stat;
        n_out  = r_out;
        n_slot = r_slot;
        n_frac = r_frac;
        n_lo   = r_lo;
        n_hi   = r_hi;
        o_pop  = 1'b0;
        scl_we = 1'b0;
        scl_wa = i_req.idx;
        scl_wd = SCL_W'(i_req.scaled);
        tbl_we = 1'b0;
        tbl_wa = r_lo;
        thr_wd = scl_lo_q[WEIGHT_W-1:0];
        als_wd = r_hi;
        sm_we  = 1'b0;
        sm_wa  = r_sc[IDX_W-1:0];
        sm_wd  = i_req.idx;
        lg_we  = 1'b0;
        lg_wa  = r_lc[IDX_W-1:0];
        lg_wd  = i_req.idx;
        case (r_st)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop  = 1'b1;
                    n_slot = i_req.idx;
                    n_frac = i_req.frac;
                    n_stat = i_req.status;
                    n_out  = '0;
                    if (i_req.status != ST_OK) begin
                        n_ov = 1'b1;
                    end else if (i_req.op == OP_SAMPLE) begin
                        if (!r_rdy) begin
                            n_stat = ST_NOT_BUILT;
                            n_ov   = 1'b1;
                        end else begin
                            n_st = S_SAMP;
                        end
                    end else begin
                        n_rdy  = 1'b0;
                        scl_we = 1'b1;
                        if (scl_wd < ONE_SCL) begin
                            if (r_sc < N_MAX) begin
                                sm_we = 1'b1;
                                n_sc  = r_sc + CNT_W'(1);
                            end
                        end else if (r_lc < N_MAX) begin
                            lg_we = 1'b1;
                            n_lc  = r_lc + CNT_W'(1);
                        end
                        if (i_req.last) begin
                            n_st = S_BUILD;
                        end else begin
                            n_ov = 1'b1;
                        end
                    end
                end
            end
            S_SAMP: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = (WEIGHT_W'(r_frac) <= thr_q) ? r_slot : als_q;
                    n_st  = S_IDLE;
                end
            end
            S_BUILD: begin
                if (r_sc != '0 && r_lc != '0) begin
                    n_sc = sc_m1;
                    n_lc = lc_m1;
                    n_st = S_PAIR_IDX;
                end else if (r_lc != '0) begin
                    n_lc = lc_m1;
                    n_st = S_LEFT_L;
                end else if (r_sc != '0) begin
                    n_sc = sc_m1;
                    n_st = S_LEFT_S;
                end else if (out_free) begin
                    n_rdy = 1'b1;
                    n_ov  = 1'b1;
                    n_st  = S_IDLE;
                end
            end
            S_PAIR_IDX: begin
                n_lo = sm_q;
                n_hi = lg_q;
                n_st = S_PAIR_UPD;
            end
            S_PAIR_UPD: begin
                tbl_we = 1'b1;
                scl_we = 1'b1;
                scl_wa = r_hi;
                scl_wd = sum;
                sm_wd  = r_hi;
                lg_wd  = r_hi;
                // negative sum means the 28-bit value wrapped: treat as large
                if (!sum[SCL_W-1] && sum < ONE_SCL) begin
                    sm_we = 1'b1;
                    n_sc  = r_sc + CNT_W'(1);
                end else begin
                    lg_we = 1'b1;
                    n_lc  = r_lc + CNT_W'(1);
                end
                n_st = S_BUILD;
            end
            S_LEFT_L: begin
                tbl_we = 1'b1;
                tbl_wa = lg_q;
                thr_wd = ONE_THR;
                als_wd = lg_q;
                n_st   = S_BUILD;
            end
            S_LEFT_S: begin
                tbl_we = 1'b1;
                tbl_wa = sm_q;
                thr_wd = ONE_THR;
                als_wd = sm_q;
                n_st   = S_BUILD;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
        if (i_cfg_clr) begin
            n_sc  = '0;
            n_lc  = '0;
            n_rdy = 1'b0;
        end
    end

    assign o_valid           = r_ov;
    assign o_status          = r_stat;
    assign o_sampled_outcome = r_out;
endmodule

/* rtl/core/alias_table_sampler_core.sv */
// Alias-method sampler. Loads (operation 0) write Q1.16 weights scaled by
// entries_in_use and sort entries onto small/large stacks; a load with
// last_entry set then builds the threshold/alias tables, walking the stacks
// pair by pair (small with large) and then the leftover entries, and its
// result is returned when the build finishes. Samples (operation 1) go
// through the registered table memory read. Other loads return their result
// directly. The front checks ranges and scales weights, a two-deep request
// queue feeds the back end that owns the memories. Writing the config
// register clears the stacks and marks the table unbuilt.
module alias_table_sampler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [8:0]  i_entry_index,
    input  logic [16:0] i_weight,
    input  logic        i_last_entry,
    input  logic [8:0]  i_random_slot,
    input  logic [15:0] i_random_fraction,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [8:0]  o_sampled_outcome,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);
    import acs_pkg::*;

    t_req req_in, req_q;
    logic push, full, pop, q_valid, cfg_clr;

    assign o_ready     = !full;
    assign o_cfg_ready = 1'b1;

    acs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid && !full),
        .i_operation       (i_operation),
        .i_entry_index     (i_entry_index),
        .i_weight          (i_weight),
        .i_last_entry      (i_last_entry),
        .i_random_slot     (i_random_slot),
        .i_random_fraction (i_random_fraction),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_push            (push),
        .o_req             (req_in),
        .o_cfg_clr         (cfg_clr)
    );

    acs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_req   (req_q)
    );

    acs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_clr         (cfg_clr),
        .i_q_valid         (q_valid),
        .i_req             (req_q),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_sampled_outcome (o_sampled_outcome)
    );
endmodule

/* rtl/core/acs_checker.sv */
module acs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [8:0] o_sampled_outcome
);
    import acs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_sampled_outcome))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_RANGE || o_status == ST_NOT_BUILT)
        else $error("bad status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_sampled_outcome == '0)
        else $error("error result carries an outcome");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind alias_table_sampler_core acs_checker u_acs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_status          (o_status),
    .o_sampled_outcome (o_sampled_outcome)
);
